// ===== src/gravity_accel_accumulator_top_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the gravity acceleration accumulator
// Clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef GRAVITY_ACCEL_ACCUMULATOR_TOP_DEFINES_SVH
`define GRAVITY_ACCEL_ACCUMULATOR_TOP_DEFINES_SVH

// same-cycle implication
`define GAA_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GAA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/gaa_pkg.sv =====
// ---------------------------------------------------------------------------
// gaa_pkg
// Types and constants shared by the gravity acceleration accumulator.
// ---------------------------------------------------------------------------
`default_nettype none

package gaa_pkg;

    // width of the shared add/subtract datapath
    localparam int UW = 106;

    localparam logic        CMD_WRITE    = 1'b0;
    localparam logic        CMD_QUERY    = 1'b1;
    localparam logic [7:0]  CFG_NUM_ATTR = 8'd0;
    localparam logic [7:0]  CFG_GRAV     = 8'd1;
    localparam logic [15:0] GRAV_RESET   = 16'd35;
    localparam logic [32:0] TERM_MAX     = 33'h1_0000_0000;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_SQRT,
        OP_DIV
    } gaa_op_t;

    typedef struct packed {
        logic        start;
        gaa_op_t     op;
    } gaa_ucmd_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic        clip;
    } gaa_ustat_t;

    typedef struct packed {
        logic               cmd;
        logic [3:0]         slot;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [23:0]        mass_value;
        logic               on_planet;
    } gaa_in_t;

    typedef struct packed {
        logic signed [31:0] accel_x;
        logic signed [31:0] accel_y;
        logic               saturated;
    } gaa_out_t;

endpackage

`default_nettype wire

// ===== src/gaa_ram.sv =====
// ---------------------------------------------------------------------------
// gaa_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module gaa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== src/gaa_unit.sv =====
// ---------------------------------------------------------------------------
// gaa_unit
// Shared bit-serial unit: shift-add multiply, digit square root and
// restoring divide, all on one wide add/subtract.
// ---------------------------------------------------------------------------
`default_nettype none

module gaa_unit (
    input  logic                   clk,
    input  logic                   rst_n,
    input  gaa_pkg::gaa_ucmd_t     ucmd,
    input  logic [gaa_pkg::UW-1:0] opa,
    input  logic [gaa_pkg::UW-1:0] opb,
    output gaa_pkg::gaa_ustat_t    ustat,
    output logic [gaa_pkg::UW-1:0] prod,
    output logic [32:0]            quo
);

    import gaa_pkg::*;

    typedef enum logic [1:0] {
        U_IDLE,
        U_CHECK,
        U_RUN
    } ustate_t;

    ustate_t       state_reg;
    gaa_op_t       op_reg;
    logic [5:0]    cnt_reg;
    logic          done_reg;
    logic          clip_reg;
    logic [UW-1:0] p_reg;
    logic [UW-1:0] a_reg;
    logic [UW-1:0] b_reg;
    logic [32:0]   q_reg;

    logic [UW-1:0] rem_sh;
    logic [UW-1:0] x;
    logic [UW-1:0] y;
    logic          sub;
    logic [UW:0]   sum;
    logic          ge;

    always_comb
    begin
        unique case (op_reg)
            OP_SQRT: rem_sh = {p_reg[UW-3:0], b_reg[65:64]};
            OP_DIV:  rem_sh = {p_reg[UW-2:0], b_reg[32]};
            default: rem_sh = p_reg;
        endcase
        x   = (state_reg == U_RUN && op_reg != OP_MUL) ? rem_sh : p_reg;
        y   = (op_reg == OP_SQRT) ? UW'({q_reg, 2'b01}) : a_reg;
        sub = (op_reg != OP_MUL);
        sum = {1'b0, x} + {1'b0, (sub ? ~y : y)} + (UW+1)'(sub);
        ge  = sum[UW];
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= U_IDLE;
            op_reg    <= OP_MUL;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
            clip_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ucmd.start)
            begin
                op_reg    <= ucmd.op;
                cnt_reg   <= 6'd32;
                clip_reg  <= 1'b0;
                state_reg <= (ucmd.op == OP_DIV) ? U_CHECK : U_RUN;
            end
            else
            begin
                unique case (state_reg)
                    U_CHECK:
                    begin
                        if (ge)
                        begin
                            clip_reg  <= 1'b1;
                            done_reg  <= 1'b1;
                            state_reg <= U_IDLE;
                        end
                        else
                        begin
                            state_reg <= U_RUN;
                        end
                    end
                    U_RUN:
                    begin
                        if (cnt_reg == 6'd0)
                        begin
                            done_reg  <= 1'b1;
                            state_reg <= U_IDLE;
                        end
                        else
                        begin
                            cnt_reg <= cnt_reg - 6'd1;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (ucmd.start)
        begin
            q_reg <= '0;
            unique case (ucmd.op)
                OP_MUL:
                begin
                    p_reg <= '0;
                    a_reg <= opa;
                    b_reg <= opb;
                end
                OP_SQRT:
                begin
                    p_reg <= '0;
                    b_reg <= opa;
                end
                OP_DIV:
                begin
                    p_reg <= opa >> 33;
                    a_reg <= opb;
                    b_reg <= opa;
                end
                default: ;
            endcase
        end
        else if (state_reg == U_RUN)
        begin
            unique case (op_reg)
                OP_MUL:
                begin
                    if (b_reg[0])
                    begin
                        p_reg <= sum[UW-1:0];
                    end
                    a_reg <= a_reg << 1;
                    b_reg <= b_reg >> 1;
                end
                OP_SQRT, OP_DIV:
                begin
                    p_reg <= ge ? sum[UW-1:0] : rem_sh;
                    q_reg <= {q_reg[31:0], ge};
                    b_reg <= (op_reg == OP_SQRT) ? (b_reg << 2) : (b_reg << 1);
                end
                default: ;
            endcase
        end
    end

    assign ustat.busy = (state_reg != U_IDLE);
    assign ustat.done = done_reg;
    assign ustat.clip = clip_reg;
    assign prod       = p_reg;
    assign quo        = q_reg;

endmodule

`default_nettype wire

// ===== src/gravity_accel_accumulator_top.sv =====
// A write is taken while the sequencer is idle; a query runs over N attractors in turn,
// N = min(num_attractors, MAX_ATTRACTORS), with less work when an attractor sits at zero
// distance or a divide clips; a resting body or N = 0 goes straight to the result.
// Throughput: one query at a time, set by the shared bit-serial unit that runs six
// multiplies, one square root and two divides per attractor.
// Reset (rst_n, async low): sequencer idle, no result pending, num_attractors 0,
// grav_const 35; the attractor table is not cleared. Writes are taken back to back.
// ---------------------------------------------------------------------------
// gravity_accel_accumulator_top
// Direct-sum gravitational acceleration over a table of attractors.
// ---------------------------------------------------------------------------
`default_nettype none
`include "gravity_accel_accumulator_top_defines.svh"

module gravity_accel_accumulator_top #(
    parameter int MAX_ATTRACTORS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    output logic             cmd_ready,
    input  gaa_pkg::gaa_in_t cmd_item,
    output logic             res_valid,
    input  logic             res_ready,
    output gaa_pkg::gaa_out_t res_item,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [7:0]       cfg_index,
    input  logic [15:0]      cfg_data
);

    import gaa_pkg::*;

    localparam int AW = (MAX_ATTRACTORS > 1) ? $clog2(MAX_ATTRACTORS) : 1;
    localparam int CW = $clog2(MAX_ATTRACTORS + 1);
    localparam int MW = 88;
    localparam logic [8:0] MAX9 = 9'(MAX_ATTRACTORS);

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_LOAD,
        S_SQX,
        S_SQY,
        S_ROOT,
        S_GM,
        S_DEN,
        S_NX,
        S_DX,
        S_NY,
        S_DY,
        S_NEXT,
        S_DONE
    } state_t;

    state_t             state_reg;
    logic [CW-1:0]      idx_reg;
    logic [CW-1:0]      n_reg;
    logic [4:0]         num_attr_reg;
    logic [15:0]        grav_reg;
    logic               res_valid_reg;
    logic               sat_reg;
    logic signed [31:0] accx_reg;
    logic signed [31:0] accy_reg;
    gaa_out_t           res_item_reg;

    logic signed [31:0] px_reg;
    logic signed [31:0] py_reg;
    logic [32:0]        mx_reg;
    logic [32:0]        my_reg;
    logic               xneg_reg;
    logic               yneg_reg;
    logic [23:0]        mass_reg;
    logic [65:0]        s_reg;
    logic [32:0]        r_reg;
    logic [39:0]        gm_reg;
    logic [98:0]        den_reg;

    logic               cmd_acc;
    logic               wr_en;
    logic [8:0]         slot9;
    logic [8:0]         n9;
    logic [MW-1:0]      rdata;
    logic [31:0]        ra_x;
    logic [31:0]        ra_y;
    logic [32:0]        dx;
    logic [32:0]        dy;
    logic [32:0]        mx_c;
    logic [32:0]        my_c;
    logic [65:0]        s_sum;

    gaa_ucmd_t          ucmd;
    gaa_ustat_t         ustat;
    logic [UW-1:0]      opa;
    logic [UW-1:0]      opb;
    logic [UW-1:0]      uprod;
    logic [32:0]        uquo;

    logic [32:0]        mag;
    logic [33:0]        term;
    logic signed [31:0] acc_sel;
    logic signed [34:0] acc_sum;
    logic signed [31:0] acc_new;
    logic               acc_clamp;
    logic               out_load;

    assign cmd_ready = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign cmd_acc   = cmd_valid && cmd_ready;
    assign slot9     = {5'b0, cmd_item.slot};
    assign wr_en     = cmd_acc && (cmd_item.cmd == CMD_WRITE) && (slot9 < MAX9);
    assign n9        = ({4'b0, num_attr_reg} > MAX9) ? MAX9 : {4'b0, num_attr_reg};

    gaa_ram #(
        .WIDTH (MW),
        .DEPTH (MAX_ATTRACTORS)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (AW'(slot9)),
        .wdata ({cmd_item.pos_x, cmd_item.pos_y, cmd_item.mass_value}),
        .raddr (idx_reg[AW-1:0]),
        .rdata (rdata)
    );

    gaa_unit u_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .ucmd  (ucmd),
        .opa   (opa),
        .opb   (opb),
        .ustat (ustat),
        .prod  (uprod),
        .quo   (uquo)
    );

    assign ra_x  = rdata[87:56];
    assign ra_y  = rdata[55:24];
    assign dx    = {ra_x[31], ra_x} - {px_reg[31], px_reg};
    assign dy    = {ra_y[31], ra_y} - {py_reg[31], py_reg};
    assign mx_c  = dx[32] ? -dx : dx;
    assign my_c  = dy[32] ? -dy : dy;
    assign s_sum = s_reg + uprod[65:0];

    // unit dispatch
    always_comb
    begin
        ucmd.start = 1'b0;
        ucmd.op    = OP_MUL;
        opa        = '0;
        opb        = '0;
        unique case (state_reg)
            S_LOAD:
            begin
                ucmd.start = 1'b1;
                opa        = UW'(mx_c);
                opb        = UW'(mx_c);
            end
            S_SQX:
            begin
                ucmd.start = ustat.done;
                opa        = UW'(my_reg);
                opb        = UW'(my_reg);
            end
            S_SQY:
            begin
                ucmd.start = ustat.done && (s_sum != '0);
                ucmd.op    = OP_SQRT;
                opa        = UW'(s_sum);
            end
            S_ROOT:
            begin
                ucmd.start = ustat.done;
                opa        = UW'(grav_reg);
                opb        = UW'(mass_reg);
            end
            S_GM:
            begin
                ucmd.start = ustat.done;
                opa        = UW'(s_reg);
                opb        = UW'(r_reg);
            end
            S_DEN:
            begin
                ucmd.start = ustat.done;
                opa        = UW'(gm_reg);
                opb        = UW'(mx_reg);
            end
            S_NX, S_NY:
            begin
                ucmd.start = ustat.done;
                ucmd.op    = OP_DIV;
                opa        = UW'({uprod[72:0], 32'h0});
                opb        = UW'(den_reg);
            end
            S_DX:
            begin
                ucmd.start = ustat.done;
                opa        = UW'(gm_reg);
                opb        = UW'(my_reg);
            end
            default: ;
        endcase
    end

    // term and saturating accumulate
    always_comb
    begin
        mag       = (ustat.clip || uquo > TERM_MAX) ? TERM_MAX : uquo;
        term      = ((state_reg == S_DX) ? xneg_reg : yneg_reg) ? -{1'b0, mag} : {1'b0, mag};
        acc_sel   = (state_reg == S_DX) ? accx_reg : accy_reg;
        acc_sum   = 35'(acc_sel) + {term[33], term};
        acc_clamp = 1'b1;
        priority if (acc_sum > 35'sd2147483647)
        begin
            acc_new = 32'sh7FFF_FFFF;
        end
        else if (acc_sum < -35'sd2147483648)
        begin
            acc_new = 32'sh8000_0000;
        end
        else
        begin
            acc_new   = acc_sum[31:0];
            acc_clamp = 1'b0;
        end
    end

    assign out_load = (state_reg == S_DONE) && (!res_valid_reg || res_ready);

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            n_reg         <= '0;
            num_attr_reg  <= '0;
            grav_reg      <= GRAV_RESET;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_NUM_ATTR)
                begin
                    num_attr_reg <= cfg_data[4:0];
                end
                else if (cfg_index == CFG_GRAV)
                begin
                    grav_reg <= cfg_data;
                end
            end
            if (out_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_valid_reg && res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_acc && cmd_item.cmd == CMD_QUERY)
                    begin
                        idx_reg <= '0;
                        n_reg   <= CW'(n9);
                        state_reg <= (cmd_item.on_planet || n9 == '0) ? S_DONE : S_READ;
                    end
                end
                S_READ: state_reg <= S_LOAD;
                S_LOAD: state_reg <= S_SQX;
                S_SQX:  if (ustat.done) state_reg <= S_SQY;
                S_SQY:  if (ustat.done) state_reg <= (s_sum != '0) ? S_ROOT : S_NEXT;
                S_ROOT: if (ustat.done) state_reg <= S_GM;
                S_GM:   if (ustat.done) state_reg <= S_DEN;
                S_DEN:  if (ustat.done) state_reg <= S_NX;
                S_NX:   if (ustat.done) state_reg <= S_DX;
                S_DX:   if (ustat.done) state_reg <= S_NY;
                S_NY:   if (ustat.done) state_reg <= S_DY;
                S_DY:   if (ustat.done) state_reg <= S_NEXT;
                S_NEXT:
                begin
                    idx_reg   <= idx_reg + 1'b1;
                    state_reg <= (idx_reg + 1'b1 == n_reg) ? S_DONE : S_READ;
                end
                S_DONE:
                begin
                    if (out_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (cmd_acc && cmd_item.cmd == CMD_QUERY)
        begin
            px_reg   <= cmd_item.pos_x;
            py_reg   <= cmd_item.pos_y;
            accx_reg <= '0;
            accy_reg <= '0;
            sat_reg  <= 1'b0;
        end
        if (state_reg == S_LOAD)
        begin
            mx_reg   <= mx_c;
            my_reg   <= my_c;
            xneg_reg <= dx[32];
            yneg_reg <= dy[32];
            mass_reg <= rdata[23:0];
        end
        if (ustat.done)
        begin
            unique case (state_reg)
                S_SQX:  s_reg   <= uprod[65:0];
                S_SQY:  s_reg   <= s_sum;
                S_ROOT: r_reg   <= uquo;
                S_GM:   gm_reg  <= uprod[39:0];
                S_DEN:  den_reg <= uprod[98:0];
                S_DX:
                begin
                    accx_reg <= acc_new;
                    sat_reg  <= sat_reg | acc_clamp;
                end
                S_DY:
                begin
                    accy_reg <= acc_new;
                    sat_reg  <= sat_reg | acc_clamp;
                end
                default: ;
            endcase
        end
        if (out_load)
        begin
            res_item_reg.accel_x   <= accx_reg;
            res_item_reg.accel_y   <= accy_reg;
            res_item_reg.saturated <= sat_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

    `GAA_ASSERT_IMPL(a_busy_blocks_cmd, ustat.busy, !cmd_ready, "unit busy while idle")
    `GAA_ASSERT_IMPL(a_start_when_free, ucmd.start, !ustat.busy, "unit restarted while busy")
    `GAA_ASSERT_IMPL(a_idx_in_range, state_reg != S_IDLE, idx_reg <= n_reg, "index past count")
    `GAA_ASSERT_NEXT(a_result_posted, out_load, res_valid, "result not posted")

endmodule

`default_nettype wire

// ===== tb/sv/tb_gravity_accel_accumulator_top.sv =====
// ---------------------------------------------------------------------------
// tb_gravity_accel_accumulator_top
// Self-checking bench for the direct-sum gravity accumulator. A scoreboard
// mirrors the attractor table and registers and predicts each query's
// saturated signed Q0.32 acceleration with wide integer arithmetic. Directed items
// cover extremes and special cases. Random phases then run under several
// register settings with random idling on both sides, after one long output hold.
// ---------------------------------------------------------------------------
`default_nettype none

class gravity_scoreboard;
    logic [31:0]           tab_x[16];
    logic [31:0]           tab_y[16];
    logic [23:0]           tab_m[16];
    logic [4:0]            n_attr;
    logic [15:0]           gconst;
    gaa_pkg::gaa_out_t     accel_q[$];
    int                    mismatches;

    function new();
        n_attr     = 0;
        gconst     = gaa_pkg::GRAV_RESET;
        mismatches = 0;
    endfunction

    function void set_reg(logic [7:0] idx, logic [15:0] d);
        if (idx == gaa_pkg::CFG_NUM_ATTR)
            n_attr = d[4:0];
        else if (idx == gaa_pkg::CFG_GRAV)
            gconst = d;
    endfunction

    function logic [127:0] isqrt(logic [127:0] s);
        logic [127:0] r;
        logic [127:0] c;
        r = 0;
        for (int b = 32; b >= 0; b--)
        begin
            c = r | (128'd1 << b);
            if (c * c <= s)
                r = c;
        end
        return r;
    endfunction

    function logic signed [63:0] pull(logic signed [32:0] d, logic [127:0] s,
                                      logic [127:0] r, logic [127:0] gm);
        logic [32:0]        m;
        logic [127:0]       num;
        logic [127:0]       q;
        logic signed [63:0] t;
        if (d == 0)
            return 0;
        m   = d[32] ? -d : d;
        num = (gm * 128'(m)) << 32;
        q   = num / (s * r);
        if (q > 128'h1_0000_0000)
            q = 128'h1_0000_0000;
        t = q[63:0];
        return d[32] ? -t : t;
    endfunction

    function logic signed [63:0] add_clamp(logic signed [63:0] acc, logic signed [63:0] t,
                                           inout logic sat);
        acc = acc + t;
        if (acc > 64'sd2147483647)
        begin
            acc = 64'sd2147483647;
            sat = 1;
        end
        if (acc < -64'sd2147483648)
        begin
            acc = -64'sd2147483648;
            sat = 1;
        end
        return acc;
    endfunction

    function void note_cmd(gaa_pkg::gaa_in_t it);
        logic signed [63:0] ax;
        logic signed [63:0] ay;
        logic               sat;
        int                 n;
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic [32:0]        mx;
        logic [32:0]        my;
        logic [127:0]       s;
        logic [127:0]       r;
        logic [127:0]       gm;
        gaa_pkg::gaa_out_t  o;
        if (it.cmd == gaa_pkg::CMD_WRITE)
        begin
            tab_x[it.slot] = it.pos_x;
            tab_y[it.slot] = it.pos_y;
            tab_m[it.slot] = it.mass_value;
            return;
        end
        ax  = 0;
        ay  = 0;
        sat = 0;
        if (!it.on_planet)
        begin
            n = (n_attr > 16) ? 16 : n_attr;
            for (int i = 0; i < n; i++)
            begin
                dx = {tab_x[i][31], tab_x[i]} - {it.pos_x[31], it.pos_x};
                dy = {tab_y[i][31], tab_y[i]} - {it.pos_y[31], it.pos_y};
                mx = dx[32] ? -dx : dx;
                my = dy[32] ? -dy : dy;
                s  = 128'(mx) * 128'(mx) + 128'(my) * 128'(my);
                if (s == 0)
                    continue;
                r  = isqrt(s);
                gm = 128'(gconst) * 128'(tab_m[i]);
                ax = add_clamp(ax, pull(dx, s, r, gm), sat);
                ay = add_clamp(ay, pull(dy, s, r, gm), sat);
            end
        end
        o.accel_x   = ax[31:0];
        o.accel_y   = ay[31:0];
        o.saturated = sat;
        accel_q.push_back(o);
    endfunction

    function void check_result(gaa_pkg::gaa_out_t got);
        gaa_pkg::gaa_out_t exp_o;
        if (accel_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result x=%h y=%h sat=%b",
                         got.accel_x, got.accel_y, got.saturated);
            return;
        end
        exp_o = accel_q.pop_front();
        if (got !== exp_o)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: exp x=%h y=%h sat=%b got x=%h y=%h sat=%b",
                         exp_o.accel_x, exp_o.accel_y, exp_o.saturated,
                         got.accel_x, got.accel_y, got.saturated);
        end
    endfunction
endclass

module tb_gravity_accel_accumulator_top;
    import gaa_pkg::*;

    localparam longint LIMIT = 20_000_000;
    // indexes with no register behind them
    localparam logic [7:0] CFG_UNUSED_LO = 8'd2;
    localparam logic [7:0] CFG_UNUSED_HI = 8'hff;

    logic     clk = 0;
    logic     rst_n;
    logic     cmd_valid;
    logic     cmd_ready;
    gaa_in_t  cmd_item;
    logic     res_valid;
    logic     res_ready;
    gaa_out_t res_item;
    logic     cfg_valid;
    logic     cfg_ready;
    logic [7:0]  cfg_index;
    logic [15:0] cfg_data;

    bit     quiet = 0;
    bit     hold_req = 0;
    longint cycles = 0;
    gravity_scoreboard sb = new();

    gravity_accel_accumulator_top dut (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd_item(cmd_item),
        .res_valid(res_valid), .res_ready(res_ready), .res_item(res_item),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("tb_gravity_accel_accumulator_top NOT OK");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && res_valid && res_ready)
            sb.check_result(res_item);

    initial
    begin
        res_ready <= 0;
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                res_ready <= 0;
                repeat (400) @(posedge clk);
                hold_req = 0;
            end
            else
            begin
                res_ready <= quiet || ($urandom_range(99) >= 13);
                @(posedge clk);
            end
        end
    end

    task automatic send_item(gaa_in_t it);
        cmd_item  <= it;
        cmd_valid <= 1;
        do @(posedge clk); while (!cmd_ready);
        sb.note_cmd(it);
        if (!quiet && $urandom_range(99) < 13)
        begin
            cmd_valid <= 0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    task automatic write_reg(logic [7:0] idx, logic [15:0] d);
        cfg_index <= idx;
        cfg_data  <= d;
        cfg_valid <= 1;
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(idx, d);
        cfg_valid <= 0;
        @(posedge clk);
    endtask

    task automatic drain();
        cmd_valid <= 0;
        @(posedge clk);
        while (sb.accel_q.size() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    function automatic gaa_in_t mk_write(logic [3:0] sl, logic [31:0] x, logic [31:0] y,
                                         logic [23:0] m);
        gaa_in_t it;
        it.cmd        = CMD_WRITE;
        it.slot       = sl;
        it.pos_x      = x;
        it.pos_y      = y;
        it.mass_value = m;
        it.on_planet  = 1'($urandom_range(1));
        return it;
    endfunction

    function automatic gaa_in_t mk_query(logic [31:0] x, logic [31:0] y, logic rest);
        gaa_in_t it;
        it.cmd        = CMD_QUERY;
        it.slot       = 4'($urandom());
        it.pos_x      = x;
        it.pos_y      = y;
        it.mass_value = 24'($urandom());
        it.on_planet  = rest;
        return it;
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(9))
            0, 1, 2: return $urandom();
            3:       return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return 32'($signed($urandom_range(131072)) - 65536);
        endcase
    endfunction

    function automatic gaa_in_t rand_item();
        int          k;
        logic [31:0] x;
        logic [31:0] y;
        logic [23:0] m;
        if ($urandom_range(99) < 40)
        begin
            case ($urandom_range(3))
                0:       m = 24'($urandom());
                1:       m = $urandom_range(1) ? 24'hff_ffff : 24'd0;
                default: m = 24'($urandom_range(4095));
            endcase
            return mk_write(4'($urandom()), rand_coord(), rand_coord(), m);
        end
        k = $urandom_range(15);
        case ($urandom_range(9))
            0: begin x = sb.tab_x[k]; y = sb.tab_y[k]; end
            1, 2, 3, 4:
            begin
                x = sb.tab_x[k] + 32'($signed($urandom_range(4096)) - 2048);
                y = sb.tab_y[k] + 32'($signed($urandom_range(4096)) - 2048);
            end
            default: begin x = rand_coord(); y = rand_coord(); end
        endcase
        return mk_query(x, y, $urandom_range(99) < 10);
    endfunction

    initial
    begin
        int n_list[12];
        int cnt;
        rst_n     = 0;
        cmd_valid <= 0;
        cmd_item  <= '0;
        cfg_valid <= 0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: fill every slot first, then extremes and special cases
        write_reg(CFG_NUM_ATTR, 16);
        write_reg(CFG_GRAV, 16'hffff);
        write_reg(CFG_UNUSED_LO, 16'h1234);
        write_reg(CFG_UNUSED_HI, 16'hffff);
        for (int i = 0; i < 16; i++)
            send_item(mk_write(4'(i), 32'(i * 1024), 32'(-i * 768),
                               (i == 0) ? 24'hff_ffff : (i == 1) ? 24'd0 : 24'(i * 1000)));
        send_item(mk_query(32'd512, 32'd0, 0));
        send_item(mk_query(32'd0, 32'd0, 0));
        send_item(mk_query(32'd100, 32'd100, 1));
        send_item(mk_query(32'h7fff_ffff, 32'h8000_0000, 0));
        send_item(mk_query(32'h8000_0000, 32'h7fff_ffff, 0));
        send_item(mk_query(32'd3, 32'hffff_fffd, 0));
        drain();

        // long output hold with fast queries so the block stalls its input
        write_reg(CFG_NUM_ATTR, 0);
        hold_req = 1;
        for (int i = 0; i < 30; i++)
            send_item(mk_query($urandom(), $urandom(), 1'($urandom_range(1))));
        drain();

        n_list = '{1, 2, 3, 0, 16, 31, 2, 1, 3, 17, 2, 1};
        for (int p = 0; p < 12; p++)
        begin
            write_reg(CFG_NUM_ATTR, 16'(n_list[p]));
            case (p % 4)
                0: write_reg(CFG_GRAV, 16'hffff);
                1: write_reg(CFG_GRAV, 0);
                2: write_reg(CFG_GRAV, 1);
                default: write_reg(CFG_GRAV, 16'($urandom()));
            endcase
            quiet = (p == 6);
            cnt = (n_list[p] >= 4) ? 30 : 200;
            for (int i = 0; i < cnt; i++)
                send_item(rand_item());
            drain();
        end
        quiet = 0;

        repeat (20) @(posedge clk);
        if (sb.mismatches == 0 && sb.accel_q.size() == 0)
            $display("tb_gravity_accel_accumulator_top OK");
        else
            $display("tb_gravity_accel_accumulator_top NOT OK");
        $finish;
    end
endmodule

`default_nettype wire
